>>> rtl/aarh_pkg.sv
// Shared types, widths and codes for the axis-aligned rectangle ray hit pipeline.
// No dependencies; the RTL files refer to it by scoped names and the bench imports it.
package aarh_pkg;

	localparam int CW   = 32;           // coordinate width
	localparam int FB   = 16;           // fraction bits
	localparam int NUMW = CW + 1;       // plane offset minus origin
	localparam int QW   = CW + FB;      // magnitude of t before range check
	localparam int PW   = 2 * CW - FB + 1; // exact hit point
	localparam int TB   = 16;           // texture fraction bits
	localparam int TW   = TB + 1;       // texture coordinate width
	localparam int MW   = 8;            // material tag width
	localparam int IW   = 3;            // register index width

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [1:0] {
		AXIS_XY = 2'd0,
		AXIS_YZ = 2'd1,
		AXIS_XZ = 2'd2
	} axis_t;

	typedef enum logic [IW-1:0] {
		REG_AXIS       = 3'd0,
		REG_OFFSET     = 3'd1,
		REG_FIRST_MIN  = 3'd2,
		REG_SECOND_MIN = 3'd3,
		REG_FIRST_MAX  = 3'd4,
		REG_SECOND_MAX = 3'd5,
		REG_MATERIAL   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]    axis;
		coord_t        offset;
		coord_t        f_min;
		coord_t        s_min;
		coord_t        f_max;
		coord_t        s_max;
		logic [MW-1:0] material;
	} cfg_t;

	typedef struct packed {
		coord_t [2:0] o;
		coord_t [2:0] d;
		coord_t       t_lo;
		coord_t       t_hi;
	} ray_t;

	// beat travelling through the t divider
	typedef struct packed {
		ray_t          ray;
		logic [CW-1:0] nmag;
		logic [CW-1:0] dmag;
		logic          neg;
		logic          miss;
		logic          front;
	} tdp_t;

	// divider result handed to the point stages
	typedef struct packed {
		ray_t          ray;
		logic [QW-1:0] q;
		logic          neg;
		logic          miss;
		logic          front;
	} tq_t;

	// beat handed to the texture dividers
	typedef struct packed {
		logic          miss;
		logic          front;
		coord_t        t;
		coord_t [2:0]  p;
		logic [CW-1:0] unum;
		logic [CW-1:0] uden;
		logic [CW-1:0] vnum;
		logic [CW-1:0] vden;
		logic          udeg;
		logic          vdeg;
	} uv_t;

endpackage

>>> rtl/aarh_cfg.sv
// Rectangle configuration registers with a valid/ready write port.
// Depends on aarh_pkg.
module aarh_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [aarh_pkg::IW-1:0]  cfg_index,
	input  logic [aarh_pkg::CW-1:0]  cfg_data,
	output aarh_pkg::cfg_t           cfg
);

	aarh_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				aarh_pkg::REG_AXIS:       cfg_q.axis     <= cfg_data[1:0];
				aarh_pkg::REG_OFFSET:     cfg_q.offset   <= cfg_data;
				aarh_pkg::REG_FIRST_MIN:  cfg_q.f_min    <= cfg_data;
				aarh_pkg::REG_SECOND_MIN: cfg_q.s_min    <= cfg_data;
				aarh_pkg::REG_FIRST_MAX:  cfg_q.f_max    <= cfg_data;
				aarh_pkg::REG_SECOND_MAX: cfg_q.s_max    <= cfg_data;
				aarh_pkg::REG_MATERIAL:   cfg_q.material <= cfg_data[aarh_pkg::MW-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/aarh_tdiv.sv
// Normal-axis selection and pipelined restoring divider for the ray parameter t.
// One quotient bit per stage. Depends on aarh_pkg.
module aarh_tdiv (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  aarh_pkg::ray_t ray,
	input  aarh_pkg::cfg_t cfg,
	output logic           out_valid,
	output aarh_pkg::tq_t  tq
);

	localparam int CW   = aarh_pkg::CW;
	localparam int FB   = aarh_pkg::FB;
	localparam int NUMW = aarh_pkg::NUMW;
	localparam int QW   = aarh_pkg::QW;

	logic [1:0]              nsel;
	logic                    bad;
	aarh_pkg::coord_t        on;
	aarh_pkg::coord_t        dn;
	logic signed [NUMW-1:0]  num;
	logic signed [NUMW-1:0]  nabs;
	aarh_pkg::tdp_t          tdp_d;

	always_comb begin
		nsel = 2'd0;
		bad  = 1'b0;
		unique case (cfg.axis)
			aarh_pkg::AXIS_XY: nsel = 2'd2;
			aarh_pkg::AXIS_YZ: nsel = 2'd0;
			aarh_pkg::AXIS_XZ: nsel = 2'd1;
			default:           bad  = 1'b1;
		endcase
	end

	assign on   = ray.o[nsel];
	assign dn   = ray.d[nsel];
	assign num  = $signed({cfg.offset[CW-1], cfg.offset}) - $signed({on[CW-1], on});
	assign nabs = num[NUMW-1] ? -num : num;

	always_comb begin
		tdp_d.ray   = ray;
		tdp_d.nmag  = nabs[CW-1:0];
		tdp_d.dmag  = dn[CW-1] ? CW'(-dn) : dn;
		tdp_d.neg   = num[NUMW-1] ^ dn[CW-1];
		tdp_d.miss  = bad || (dn == '0);
		tdp_d.front = dn[CW-1];
	end

	logic           valid_s1;
	aarh_pkg::tdp_t tdp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdp_s1 <= tdp_d;
		end
	end

	// divider stages, most significant quotient bit first
	logic           valid_s2 [QW];
	logic [CW-1:0]  rem_s2   [QW];
	logic [QW-1:0]  quo_s2   [QW];
	aarh_pkg::tdp_t tdp_s2   [QW];

	genvar k;
	for (k = 0; k < QW; k++) begin : g_div
		localparam int BI = QW - 1 - k;
		logic           vin;
		logic [CW-1:0]  rin;
		logic [QW-1:0]  qin;
		aarh_pkg::tdp_t pin;
		logic           nb;
		logic [CW:0]    sh;
		logic           ge;

		if (k == 0) begin : g_first
			assign vin = valid_s1;
			assign rin = '0;
			assign qin = '0;
			assign pin = tdp_s1;
		end else begin : g_next
			assign vin = valid_s2[k-1];
			assign rin = rem_s2[k-1];
			assign qin = quo_s2[k-1];
			assign pin = tdp_s2[k-1];
		end

		// dividend is the magnitude shifted up by the fraction bits
		if (BI >= FB) begin : g_nb
			assign nb = pin.nmag[BI-FB];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign sh = {rin, nb};
		assign ge = sh >= {1'b0, pin.dmag};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s2[k] <= 1'b0;
			end else if (adv) begin
				valid_s2[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s2[k] <= ge ? CW'(sh - {1'b0, pin.dmag}) : sh[CW-1:0];
				quo_s2[k] <= {qin[QW-2:0], ge};
				tdp_s2[k] <= pin;
			end
		end
	end

	assign out_valid = valid_s2[QW-1];

	always_comb begin
		tq.ray   = tdp_s2[QW-1].ray;
		tq.q     = quo_s2[QW-1];
		tq.neg   = tdp_s2[QW-1].neg;
		tq.miss  = tdp_s2[QW-1].miss;
		tq.front = tdp_s2[QW-1].front;
	end

endmodule

>>> rtl/aarh_pt.sv
// Range test on t, direction products, hit point and bounds test.
// Four register stages. Depends on aarh_pkg.
module aarh_pt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  aarh_pkg::tq_t  tq,
	input  aarh_pkg::cfg_t cfg,
	output logic           out_valid,
	output aarh_pkg::uv_t  uv
);

	localparam int CW = aarh_pkg::CW;
	localparam int FB = aarh_pkg::FB;
	localparam int QW = aarh_pkg::QW;
	localparam int PW = aarh_pkg::PW;

	function automatic aarh_pkg::coord_t sat(input logic signed [PW-1:0] v);
		logic all1;
		logic all0;
		all1 = &v[PW-1:CW-1];
		all0 = ~|v[PW-1:CW-1];
		if (all1 || all0) begin
			return v[CW-1:0];
		end
		return v[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	function automatic logic signed [PW-1:0] ext(input aarh_pkg::coord_t c);
		return {{(PW-CW){c[CW-1]}}, c};
	endfunction

	// s3: signed t and range test
	logic signed [QW:0] tmag, tw, tlo, thi;
	assign tmag = $signed({1'b0, tq.q});
	assign tw   = tq.neg ? -tmag : tmag;
	assign tlo  = {{(QW+1-CW){tq.ray.t_lo[CW-1]}}, tq.ray.t_lo};
	assign thi  = {{(QW+1-CW){tq.ray.t_hi[CW-1]}}, tq.ray.t_hi};

	logic             valid_s3, miss_s3, front_s3;
	aarh_pkg::coord_t t_s3;
	aarh_pkg::ray_t   ray_s3;

	// s4: t times each direction component
	logic                     valid_s4, miss_s4, front_s4;
	aarh_pkg::coord_t         t_s4;
	aarh_pkg::coord_t [2:0]   o_s4;
	logic signed [2*CW-1:0]   prod_s4 [3];

	// s5: exact point
	logic                     valid_s5, miss_s5, front_s5;
	aarh_pkg::coord_t         t_s5;
	logic signed [PW-1:0]     p_s5 [3];

	// s6: bounds and texture operands
	logic                     valid_s6;
	aarh_pkg::uv_t            uv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3     <= tw[CW-1:0];
			ray_s3   <= tq.ray;
			miss_s3  <= tq.miss || (tw < tlo) || (tw > thi);
			front_s3 <= tq.front;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s4     <= t_s3;
			o_s4     <= ray_s3.o;
			miss_s4  <= miss_s3;
			front_s4 <= front_s3;
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= t_s3 * $signed(ray_s3.d[i]);
			end
		end
	end

	// arithmetic shift of the product is the floor division by 2^FB
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s5     <= t_s4;
			miss_s5  <= miss_s4;
			front_s5 <= front_s4;
			for (int i = 0; i < 3; i++) begin
				p_s5[i] <= ext(o_s4[i]) +
					$signed({prod_s4[i][2*CW-1], prod_s4[i][2*CW-1:FB]});
			end
		end
	end

	logic signed [PW-1:0] pa1, pa2, fmin, fmax, smin, smax, ud, vd;
	logic                 out_of_bounds;

	always_comb begin
		pa1 = p_s5[0];
		pa2 = p_s5[1];
		case (cfg.axis)
			aarh_pkg::AXIS_YZ: begin
				pa1 = p_s5[1];
				pa2 = p_s5[2];
			end
			aarh_pkg::AXIS_XZ: begin
				pa1 = p_s5[0];
				pa2 = p_s5[2];
			end
			default: begin
				pa1 = p_s5[0];
				pa2 = p_s5[1];
			end
		endcase
		fmin = ext(cfg.f_min);
		fmax = ext(cfg.f_max);
		smin = ext(cfg.s_min);
		smax = ext(cfg.s_max);
		ud   = fmax - fmin;
		vd   = smax - smin;
		out_of_bounds = (pa1 < fmin) || (pa1 > fmax) || (pa2 < smin) || (pa2 > smax);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			uv_s6.miss  <= miss_s5 || out_of_bounds;
			uv_s6.front <= front_s5;
			uv_s6.t     <= t_s5;
			uv_s6.p[0]  <= sat(p_s5[0]);
			uv_s6.p[1]  <= sat(p_s5[1]);
			uv_s6.p[2]  <= sat(p_s5[2]);
			uv_s6.unum  <= CW'(pa1 - fmin);
			uv_s6.vnum  <= CW'(pa2 - smin);
			uv_s6.uden  <= ud[CW-1:0];
			uv_s6.vden  <= vd[CW-1:0];
			uv_s6.udeg  <= (ud[CW-1:0] == '0);
			uv_s6.vdeg  <= (vd[CW-1:0] == '0);
		end
	end

	assign out_valid = valid_s6;
	assign uv        = uv_s6;

endmodule

>>> rtl/aarh_uvdiv.sv
// Twin pipelined dividers for the texture coordinates, then the result register.
// Depends on aarh_pkg.
module aarh_uvdiv (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  aarh_pkg::uv_t           uv,
	input  aarh_pkg::cfg_t          cfg,
	output logic                    out_valid,
	output logic                    hit,
	output logic [aarh_pkg::CW-1:0] hit_t,
	output logic [aarh_pkg::CW-1:0] point_x,
	output logic [aarh_pkg::CW-1:0] point_y,
	output logic [aarh_pkg::CW-1:0] point_z,
	output logic                    front_face,
	output logic [aarh_pkg::TW-1:0] tex_u,
	output logic [aarh_pkg::TW-1:0] tex_v,
	output logic [aarh_pkg::MW-1:0] hit_material
);

	localparam int CW = aarh_pkg::CW;
	localparam int TW = aarh_pkg::TW;

	logic          valid_s7 [TW];
	logic [CW-1:0] urem_s7  [TW];
	logic [CW-1:0] vrem_s7  [TW];
	logic [TW-1:0] uq_s7    [TW];
	logic [TW-1:0] vq_s7    [TW];
	aarh_pkg::uv_t uvp_s7   [TW];

	// on a hit the numerator never exceeds the range, so the quotient fits TW bits
	// and the first partial remainder is the numerator shifted down by one
	genvar k;
	for (k = 0; k < TW; k++) begin : g_div
		logic          vin;
		logic [CW-1:0] urin, vrin;
		logic [TW-1:0] uqin, vqin;
		aarh_pkg::uv_t pin;
		logic          unb, vnb;
		logic [CW:0]   ush, vsh;
		logic          uge, vge;

		if (k == 0) begin : g_first
			assign vin  = in_valid;
			assign urin = {1'b0, uv.unum[CW-1:1]};
			assign vrin = {1'b0, uv.vnum[CW-1:1]};
			assign uqin = '0;
			assign vqin = '0;
			assign pin  = uv;
			assign unb  = uv.unum[0];
			assign vnb  = uv.vnum[0];
		end else begin : g_next
			assign vin  = valid_s7[k-1];
			assign urin = urem_s7[k-1];
			assign vrin = vrem_s7[k-1];
			assign uqin = uq_s7[k-1];
			assign vqin = vq_s7[k-1];
			assign pin  = uvp_s7[k-1];
			assign unb  = 1'b0;
			assign vnb  = 1'b0;
		end

		assign ush = {urin, unb};
		assign vsh = {vrin, vnb};
		assign uge = ush >= {1'b0, pin.uden};
		assign vge = vsh >= {1'b0, pin.vden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s7[k] <= 1'b0;
			end else if (adv) begin
				valid_s7[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				urem_s7[k] <= uge ? CW'(ush - {1'b0, pin.uden}) : ush[CW-1:0];
				vrem_s7[k] <= vge ? CW'(vsh - {1'b0, pin.vden}) : vsh[CW-1:0];
				uq_s7[k]   <= {uqin[TW-2:0], uge};
				vq_s7[k]   <= {vqin[TW-2:0], vge};
				uvp_s7[k]  <= pin;
			end
		end
	end

	aarh_pkg::uv_t last;
	logic          hit_d;
	assign last  = uvp_s7[TW-1];
	assign hit_d = !last.miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s7[TW-1];
		end
	end

	// a miss clears every field
	always_ff @(posedge clk) begin
		if (adv) begin
			hit          <= hit_d;
			hit_t        <= hit_d ? last.t    : '0;
			point_x      <= hit_d ? last.p[0] : '0;
			point_y      <= hit_d ? last.p[1] : '0;
			point_z      <= hit_d ? last.p[2] : '0;
			front_face   <= hit_d && last.front;
			tex_u        <= (hit_d && !last.udeg) ? uq_s7[TW-1] : '0;
			tex_v        <= (hit_d && !last.vdeg) ? vq_s7[TW-1] : '0;
			hit_material <= hit_d ? cfg.material : '0;
		end
	end

endmodule

>>> rtl/axis_aligned_rect_ray_hit.sv
// Ray against axis-aligned rectangle, fully pipelined.
// Stages from input beat to result beat: entry stage, 48 t-divider
// stages, four point stages, 17 texture-divider stages and the result register.
// Throughput one ray per cycle unless stalled; the whole pipeline holds while out_valid and out_stall are both high.
// Reset clears all valid bits and the configuration registers to zero.
module axis_aligned_rect_ray_hit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [aarh_pkg::IW-1:0]      cfg_index,
	input  logic [aarh_pkg::CW-1:0]      cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [aarh_pkg::CW-1:0] origin_x,
	input  logic signed [aarh_pkg::CW-1:0] origin_y,
	input  logic signed [aarh_pkg::CW-1:0] origin_z,
	input  logic signed [aarh_pkg::CW-1:0] dir_x,
	input  logic signed [aarh_pkg::CW-1:0] dir_y,
	input  logic signed [aarh_pkg::CW-1:0] dir_z,
	input  logic signed [aarh_pkg::CW-1:0] t_lower,
	input  logic signed [aarh_pkg::CW-1:0] t_upper,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic signed [aarh_pkg::CW-1:0] hit_t,
	output logic signed [aarh_pkg::CW-1:0] point_x,
	output logic signed [aarh_pkg::CW-1:0] point_y,
	output logic signed [aarh_pkg::CW-1:0] point_z,
	output logic                         front_face,
	output logic [aarh_pkg::TW-1:0]      tex_u,
	output logic [aarh_pkg::TW-1:0]      tex_v,
	output logic [aarh_pkg::MW-1:0]      hit_material
);

	aarh_pkg::cfg_t cfg;
	aarh_pkg::ray_t ray;
	aarh_pkg::tq_t  tq;
	aarh_pkg::uv_t  uv;
	logic           adv, tq_valid, uv_valid;

	// every stage moves unless a result beat sits stalled at the output
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_comb begin
		ray.o[0] = origin_x;
		ray.o[1] = origin_y;
		ray.o[2] = origin_z;
		ray.d[0] = dir_x;
		ray.d[1] = dir_y;
		ray.d[2] = dir_z;
		ray.t_lo = t_lower;
		ray.t_hi = t_upper;
	end

	aarh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aarh_tdiv u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.ray       (ray),
		.cfg       (cfg),
		.out_valid (tq_valid),
		.tq        (tq)
	);

	aarh_pt u_pt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (tq_valid),
		.tq        (tq),
		.cfg       (cfg),
		.out_valid (uv_valid),
		.uv        (uv)
	);

	aarh_uvdiv u_uvdiv (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (uv_valid),
		.uv           (uv),
		.cfg          (cfg),
		.out_valid    (out_valid),
		.hit          (hit),
		.hit_t        (hit_t),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.front_face   (front_face),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.hit_material (hit_material)
	);

endmodule

>>> tb/tb_axis_aligned_rect_ray_hit.sv
// Self-checking bench for axis_aligned_rect_ray_hit: directed rays, then aimed and noise rays
// over several rectangle settings. Expected hits come from a local integer model of the test.
// Depends on rtl/aarh_pkg.sv and rtl/axis_aligned_rect_ray_hit.sv.
module tb_axis_aligned_rect_ray_hit;
	import aarh_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int N_PHASES    = 8;
	localparam int PHASE_RAYS  = 82;
	localparam longint ONE     = 64'sd65536;

	typedef struct packed {
		logic          hit;
		coord_t        t;
		coord_t [2:0]  p;
		logic          front;
		logic [TW-1:0] u;
		logic [TW-1:0] v;
		logic [MW-1:0] mat;
	} hit_res_t;

	typedef struct {
		ray_t     ray;
		bit       typed;
		hit_res_t res;
	} ray_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t origin_x = '0, origin_y = '0, origin_z = '0;
	coord_t dir_x = '0, dir_y = '0, dir_z = '0;
	coord_t t_lower = '0, t_upper = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit, front_face;
	coord_t hit_t, point_x, point_y, point_z;
	logic [TW-1:0] tex_u, tex_v;
	logic [MW-1:0] hit_material;

	cfg_t rect;
	hit_res_t hits_due[$];
	int errors = 0;
	int quiet = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	always #10 clk = ~clk;

	axis_aligned_rect_ray_hit uut (.*);

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic coord_t sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return coord_t'(v);
	endfunction

	function automatic logic [TW-1:0] tex_of(longint pc, longint lo, longint hi);
		longint span;
		span = hi - lo;
		if (span <= 0)
			return '0;
		return TW'(((pc - lo) * ONE) / span);
	endfunction

	function automatic void axes_of(logic [1:0] ax, output int n, output int a1, output int a2);
		case (ax)
			AXIS_YZ: begin n = 0; a1 = 1; a2 = 2; end
			AXIS_XZ: begin n = 1; a1 = 0; a2 = 2; end
			default: begin n = 2; a1 = 0; a2 = 1; end
		endcase
	endfunction

	function automatic hit_res_t trace_ray(ray_t r);
		hit_res_t res;
		longint o[3], d[3], p[3];
		longint t, k, fmin, fmax, smin, smax;
		int n, a1, a2;
		res = '0;
		if (rect.axis != AXIS_XY && rect.axis != AXIS_YZ && rect.axis != AXIS_XZ)
			return res;
		axes_of(rect.axis, n, a1, a2);
		for (int i = 0; i < 3; i++) begin
			o[i] = longint'($signed(r.o[i]));
			d[i] = longint'($signed(r.d[i]));
		end
		if (d[n] == 0)
			return res;
		k = longint'($signed(rect.offset));
		t = ((k - o[n]) * ONE) / d[n];
		if (t < longint'($signed(r.t_lo)) || t > longint'($signed(r.t_hi)))
			return res;
		for (int i = 0; i < 3; i++)
			p[i] = o[i] + ((t * d[i]) >>> FB);
		fmin = longint'($signed(rect.f_min));
		fmax = longint'($signed(rect.f_max));
		smin = longint'($signed(rect.s_min));
		smax = longint'($signed(rect.s_max));
		if (p[a1] < fmin || p[a1] > fmax || p[a2] < smin || p[a2] > smax)
			return res;
		res.hit = 1'b1;
		res.t = sat32(t);
		for (int i = 0; i < 3; i++)
			res.p[i] = sat32(p[i]);
		res.front = d[n] < 0;
		res.u = tex_of(p[a1], fmin, fmax);
		res.v = tex_of(p[a2], smin, smax);
		res.mat = rect.material;
		return res;
	endfunction

	// one idle cycle before about a fifth of the beats
	task automatic send_ray(ray_t r, bit typed = 1'b0, hit_res_t res = '0);
		if (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= r.o[0]; origin_y <= r.o[1]; origin_z <= r.o[2];
		dir_x <= r.d[0]; dir_y <= r.d[1]; dir_z <= r.d[2];
		t_lower <= r.t_lo; t_upper <= r.t_hi;
		do @(posedge clk); while (in_stall);
		hits_due.push_back(typed ? res : trace_ray(r));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (hits_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_AXIS:       rect.axis = val[1:0];
			REG_OFFSET:     rect.offset = val;
			REG_FIRST_MIN:  rect.f_min = val;
			REG_SECOND_MIN: rect.s_min = val;
			REG_FIRST_MAX:  rect.f_max = val;
			REG_SECOND_MAX: rect.s_max = val;
			REG_MATERIAL:   rect.material = val[MW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_rect(logic [1:0] ax, coord_t off, coord_t fmin, coord_t smin,
			coord_t fmax, coord_t smax, logic [MW-1:0] mat);
		drain();
		write_reg(REG_AXIS, CW'(ax));
		write_reg(REG_OFFSET, off);
		write_reg(REG_FIRST_MIN, fmin);
		write_reg(REG_SECOND_MIN, smin);
		write_reg(REG_FIRST_MAX, fmax);
		write_reg(REG_SECOND_MAX, smax);
		write_reg(REG_MATERIAL, CW'(mat));
		cfg_valid <= 1'b0;
	endtask

	function automatic ray_t mk_ray(longint ox, longint oy, longint oz, longint dx,
			longint dy, longint dz, longint lo, longint hi);
		ray_t r;
		r.o[0] = coord_t'(ox); r.o[1] = coord_t'(oy); r.o[2] = coord_t'(oz);
		r.d[0] = coord_t'(dx); r.d[1] = coord_t'(dy); r.d[2] = coord_t'(dz);
		r.t_lo = coord_t'(lo); r.t_hi = coord_t'(hi);
		return r;
	endfunction

	function automatic longint pick_in(coord_t lo, coord_t hi);
		longint l, h;
		l = longint'($signed(lo));
		h = longint'($signed(hi));
		if (l < -64 * ONE) l = -64 * ONE;
		if (h > 64 * ONE) h = 64 * ONE;
		if (l > h)
			return longint'($urandom_range(8 * ONE)) - 4 * ONE;
		return l + longint'($urandom_range(32'(h - l)));
	endfunction

	// ray built backwards from a point on the rectangle, so most of these hit
	function automatic ray_t aimed_ray();
		ray_t r;
		longint p[3], d[3], t, lo, hi;
		int n, a1, a2;
		axes_of(rect.axis, n, a1, a2);
		t = $urandom_range(20 * ONE);
		for (int i = 0; i < 3; i++)
			d[i] = longint'($urandom_range(8 * ONE)) - 4 * ONE;
		if (d[n] == 0)
			d[n] = ONE;
		p[n] = longint'($signed(rect.offset));
		p[a1] = pick_in(rect.f_min, rect.f_max);
		p[a2] = pick_in(rect.s_min, rect.s_max);
		for (int i = 0; i < 3; i++) begin
			r.o[i] = coord_t'(p[i] - ((t * d[i]) >>> FB));
			r.d[i] = coord_t'(d[i]);
		end
		lo = t - $urandom_range(ONE);
		hi = t + $urandom_range(ONE);
		if ($urandom_range(9) == 0) begin
			r.t_lo = coord_t'(hi); r.t_hi = coord_t'(lo);
		end else begin
			r.t_lo = coord_t'(lo); r.t_hi = coord_t'(hi);
		end
		return r;
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		for (int i = 0; i < 3; i++) begin
			r.o[i] = $urandom;
			r.d[i] = $urandom;
		end
		r.t_lo = $urandom;
		r.t_hi = $urandom;
		return r;
	endfunction

	// result side: checks each beat, stalls at random, one long hold-off on request
	initial begin
		hit_res_t want;
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (hits_due.size() == 0) begin
					report("unexpected result beat", 1, 0);
				end else begin
					want = hits_due.pop_front();
					if (hit !== want.hit) report("hit", hit, want.hit);
					if (hit_t !== want.t) report("hit_t", hit_t, $signed(want.t));
					if (point_x !== want.p[0]) report("point_x", point_x, $signed(want.p[0]));
					if (point_y !== want.p[1]) report("point_y", point_y, $signed(want.p[1]));
					if (point_z !== want.p[2]) report("point_z", point_z, $signed(want.p[2]));
					if (front_face !== want.front) report("front_face", front_face, want.front);
					if (tex_u !== want.u) report("tex_u", tex_u, want.u);
					if (tex_v !== want.v) report("tex_v", tex_v, want.v);
					if (hit_material !== want.mat) report("hit_material", hit_material, want.mat);
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && $urandom_range(99) < 19;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet);
			$display("tb_axis_aligned_rect_ray_hit: FAIL");
			$finish;
		end
	end

	initial begin
		ray_row_t rows[$];
		ray_row_t row;
		hit_res_t reset_hit;
		longint mx, mn;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		rect = '0;

		reset_hit = '0;
		reset_hit.hit = 1'b1;
		reset_hit.t = coord_t'(ONE);
		// first two rows run on the reset rectangle: a point at the origin
		row.typed = 1'b1;
		row.res = reset_hit;
		row.ray = mk_ray(0, 0, -ONE, 0, 0, ONE, 0, mx);
		rows.push_back(row);
		row.res = '0;
		row.ray = mk_ray(0, 0, -ONE, ONE, ONE, 0, mn, mx);
		rows.push_back(row);
		row.ray = mk_ray(0, 0, 0, 0, 0, ONE, 2 * ONE, ONE);
		rows.push_back(row);
		row.ray = mk_ray(ONE, ONE, 0, ONE, -ONE, 0, mn, mx);
		rows.push_back(row);
		row.typed = 1'b0;
		row.ray = mk_ray(0, 0, 0, 0, 0, ONE, 0, 10 * ONE);          rows.push_back(row);
		row.ray = mk_ray(0, 0, 3 * ONE, 0, 0, -ONE, 0, 10 * ONE);   rows.push_back(row);
		row.ray = mk_ray(2 * ONE, 2 * ONE, 0, 0, 0, ONE, 0, mx);     rows.push_back(row);
		row.ray = mk_ray(-2 * ONE, -2 * ONE, 0, 0, 0, ONE, 0, mx);   rows.push_back(row);
		row.ray = mk_ray(3 * ONE, 0, 0, 0, 0, ONE, 0, mx);           rows.push_back(row);
		row.ray = mk_ray(0, 0, 0, 0, 0, ONE, 0, ONE / 2);            rows.push_back(row);
		row.ray = mk_ray(mn, mn, mn, mx, mx, mx, mn, mx);            rows.push_back(row);
		row.ray = mk_ray(mx, mx, mx, mn, mn, mn, mn, mx);            rows.push_back(row);
		row.ray = mk_ray(0, 0, 0, 0, 0, 1, mn, mx);                  rows.push_back(row);
		row.ray = mk_ray(0, 0, 0, 0, 0, 0, 0, 0);                    rows.push_back(row);
		row.ray = mk_ray(ONE, -ONE, 0, ONE, ONE, ONE, ONE, ONE);      rows.push_back(row);
		row.ray = mk_ray(-1, -1, -1, -1, -1, -1, -1, -1);            rows.push_back(row);
		row.ray = mk_ray(0, 0, 2 * ONE, ONE / 3, -ONE / 5, -3 * ONE, mn, mx);
		rows.push_back(row);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (i == 2)
				set_rect(AXIS_XY, ONE, -2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE, 8'h5a);
			send_ray(rows[i].ray, rows[i].typed, rows[i].res);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: set_rect(AXIS_XY, ONE, -4 * ONE, -3 * ONE, 4 * ONE, 5 * ONE, $urandom);
				1: set_rect(AXIS_YZ, $urandom_range(8 * ONE) - 4 * ONE, -ONE, -7 * ONE,
						6 * ONE, ONE / 2, $urandom);
				2: set_rect(AXIS_XZ, -3 * ONE, -10 * ONE, 0, 0, 10 * ONE, $urandom);
				3: set_rect(2'd3, ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 8'hff);
				4: set_rect(AXIS_XY, 32'h7fffffff, 32'h80000000, 32'h80000000,
						32'h7fffffff, 32'h7fffffff, 8'hff);
				5: set_rect(AXIS_YZ, 32'h80000000, 4 * ONE, -2 * ONE, 2 * ONE, 2 * ONE, 8'h00);
				6: set_rect(AXIS_XZ, 0, ONE, -ONE, ONE, ONE, $urandom);
				default: set_rect($urandom_range(2), $urandom_range(4 * ONE),
						-($urandom_range(20 * ONE)), -($urandom_range(20 * ONE)),
						$urandom_range(20 * ONE), $urandom_range(20 * ONE), $urandom);
			endcase
			calm = (ph == N_PHASES - 1);
			for (int i = 0; i < PHASE_RAYS; i++) begin
				if (ph == 1 && i == 20)
					hold_req = 1'b1;
				send_ray($urandom_range(9) < 7 ? aimed_ray() : noise_ray());
			end
		end
		calm = 1'b0;
		drain();
		repeat (80) @(posedge clk);

		if (errors == 0 && hits_due.size() == 0)
			$display("tb_axis_aligned_rect_ray_hit: PASS");
		else
			$display("tb_axis_aligned_rect_ray_hit: FAIL");
		$finish;
	end
endmodule
